// ----- sv/wakeup_timer_with_bark_bite_watchdog_top_defines.svh -----
// Assertion macros shared by the wakeup timer and watchdog RTL.
`ifndef WAKEUP_TIMER_WITH_BARK_BITE_WATCHDOG_TOP_DEFINES_SVH
`define WAKEUP_TIMER_WITH_BARK_BITE_WATCHDOG_TOP_DEFINES_SVH

// Checked at every rising edge of i_clk, switched off while reset is held.
`define WTBW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every rising edge of i_clk, during reset as well.
`define WTBW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- sv/wtbw_pkg.sv -----
// Package with the types, register offsets and command codes of the wakeup timer and watchdog.
package wtbw_pkg;

    localparam int unsigned PRESCALE_BITS_DEF = 12;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [3:0] REG_ALERT_TEST      = 4'd0;
    localparam logic [3:0] REG_WKUP_CTRL       = 4'd1;
    localparam logic [3:0] REG_WKUP_THOLD      = 4'd2;
    localparam logic [3:0] REG_WKUP_COUNT      = 4'd3;
    localparam logic [3:0] REG_WDOG_REGWEN     = 4'd4;
    localparam logic [3:0] REG_WDOG_CTRL       = 4'd5;
    localparam logic [3:0] REG_WDOG_BARK_THOLD = 4'd6;
    localparam logic [3:0] REG_WDOG_BITE_THOLD = 4'd7;
    localparam logic [3:0] REG_WDOG_COUNT      = 4'd8;
    localparam logic [3:0] REG_INTR_STATE      = 4'd9;
    localparam logic [3:0] REG_INTR_TEST       = 4'd10;
    localparam logic [3:0] REG_WKUP_CAUSE      = 4'd11;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        wakeup_irq;
        logic        bark_irq;
        logic        bite_reset;
        logic        fatal_alert;
    } t_out_item;

endpackage

// ----- sv/wakeup_timer_with_bark_bite_watchdog_top.sv -----
// Top level of the wakeup timer with the two-stage bark and bite watchdog.
// The block takes one transfer per clock cycle on its input channel when the output does not
// stall, be it a tick, a register read or a register write, and gives exactly one result
// transfer for each. A transfer is captured in the input register and is then written to the
// result register, from which its result is offered. The throughput of one item a cycle is
// set by the state update, whose longest path is a 32-bit counter increment followed by the
// threshold compares. While a result waits on a stalled output, the next item is held in the
// input register and the input channel stalls until the result is taken.
`include "wakeup_timer_with_bark_bite_watchdog_top_defines.svh"

module wakeup_timer_with_bark_bite_watchdog_top
    import wtbw_pkg::*;
#(
    parameter int unsigned PRESCALE_BITS = PRESCALE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic                     r_in_valid;
    t_in_item                 r_in_item;
    logic                     r_out_valid;
    t_out_item                r_out_item;
    logic                     w_advance;

    logic                     r_wake_enable,    n_wake_enable;
    logic [PRESCALE_BITS-1:0] r_wake_prescale,  n_wake_prescale;
    logic [PRESCALE_BITS-1:0] r_prescale_phase, n_prescale_phase;
    logic [31:0]              r_wake_threshold, n_wake_threshold;
    logic [31:0]              r_wake_counter,   n_wake_counter;
    logic                     r_dog_write_open, n_dog_write_open;
    logic                     r_dog_enable,     n_dog_enable;
    logic                     r_dog_pause_bit,  n_dog_pause_bit;
    logic [31:0]              r_bark_threshold, n_bark_threshold;
    logic [31:0]              r_bite_threshold, n_bite_threshold;
    logic [31:0]              r_dog_counter,    n_dog_counter;
    logic [1:0]               r_irq_pending,    n_irq_pending;
    logic                     r_bitten,         n_bitten;
    logic                     r_alert_latched,  n_alert_latched;

    logic                     w_check_wake;
    logic                     w_check_dog;
    logic [31:0]              w_read_data;
    t_out_item                w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_wake_enable    = r_wake_enable;
        n_wake_prescale  = r_wake_prescale;
        n_prescale_phase = r_prescale_phase;
        n_wake_threshold = r_wake_threshold;
        n_wake_counter   = r_wake_counter;
        n_dog_write_open = r_dog_write_open;
        n_dog_enable     = r_dog_enable;
        n_dog_pause_bit  = r_dog_pause_bit;
        n_bark_threshold = r_bark_threshold;
        n_bite_threshold = r_bite_threshold;
        n_dog_counter    = r_dog_counter;
        n_irq_pending    = r_irq_pending;
        n_bitten         = r_bitten;
        n_alert_latched  = r_alert_latched;
        w_check_wake     = 1'b0;
        w_check_dog      = 1'b0;
        w_read_data      = '0;

        if (w_advance) begin
            unique case (r_in_item.cmd)
                CMD_TICK: begin
                    if (r_wake_enable) begin
                        if (r_prescale_phase >= r_wake_prescale) begin
                            n_prescale_phase = '0;
                            n_wake_counter   = r_wake_counter + 32'd1;
                        end else begin
                            n_prescale_phase = r_prescale_phase + PRESCALE_BITS'(1);
                        end
                    end
                    if (r_dog_enable) begin
                        n_dog_counter = r_dog_counter + 32'd1;
                    end
                    w_check_wake = 1'b1;
                    w_check_dog  = 1'b1;
                end
                CMD_READ: begin
                    unique case (r_in_item.reg_index)
                        REG_WKUP_CTRL:       w_read_data = {{(31 - PRESCALE_BITS){1'b0}},
                                                            r_wake_prescale, r_wake_enable};
                        REG_WKUP_THOLD:      w_read_data = r_wake_threshold;
                        REG_WKUP_COUNT:      w_read_data = r_wake_counter;
                        REG_WDOG_REGWEN:     w_read_data = {31'd0, r_dog_write_open};
                        REG_WDOG_CTRL:       w_read_data = {30'd0, r_dog_pause_bit,
                                                            r_dog_enable};
                        REG_WDOG_BARK_THOLD: w_read_data = r_bark_threshold;
                        REG_WDOG_BITE_THOLD: w_read_data = r_bite_threshold;
                        REG_WDOG_COUNT:      w_read_data = r_dog_counter;
                        REG_INTR_STATE:      w_read_data = {30'd0, r_irq_pending};
                        REG_WKUP_CAUSE:      w_read_data = '0;
                        default:             w_read_data = '0;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (r_in_item.reg_index)
                        REG_ALERT_TEST: begin
                            n_alert_latched = r_alert_latched | r_in_item.write_data[0];
                        end
                        REG_WKUP_CTRL: begin
                            n_wake_enable   = r_in_item.write_data[0];
                            n_wake_prescale = r_in_item.write_data[PRESCALE_BITS:1];
                            if (r_in_item.write_data[0] && !r_wake_enable) begin
                                n_prescale_phase = '0;
                                w_check_wake     = 1'b1;
                            end
                        end
                        REG_WKUP_THOLD: begin
                            n_wake_threshold = r_in_item.write_data;
                            w_check_wake     = 1'b1;
                        end
                        REG_WKUP_COUNT: begin
                            n_wake_counter   = r_in_item.write_data;
                            n_prescale_phase = '0;
                            w_check_wake     = 1'b1;
                        end
                        REG_WDOG_REGWEN: begin
                            n_dog_write_open = r_dog_write_open & r_in_item.write_data[0];
                        end
                        REG_WDOG_CTRL: begin
                            if (r_dog_write_open) begin
                                n_dog_enable    = r_in_item.write_data[0];
                                n_dog_pause_bit = r_in_item.write_data[1];
                                w_check_dog     = r_in_item.write_data[0] && !r_dog_enable;
                            end
                        end
                        REG_WDOG_BARK_THOLD: begin
                            if (r_dog_write_open) begin
                                n_bark_threshold = r_in_item.write_data;
                                w_check_dog      = 1'b1;
                            end
                        end
                        REG_WDOG_BITE_THOLD: begin
                            if (r_dog_write_open) begin
                                n_bite_threshold = r_in_item.write_data;
                                w_check_dog      = 1'b1;
                            end
                        end
                        REG_WDOG_COUNT: begin
                            n_dog_counter = r_in_item.write_data;
                            w_check_dog   = 1'b1;
                        end
                        REG_INTR_STATE: begin
                            n_irq_pending = r_irq_pending & ~r_in_item.write_data[1:0];
                        end
                        REG_INTR_TEST: begin
                            n_irq_pending = r_irq_pending | r_in_item.write_data[1:0];
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase

            if (w_check_wake && n_wake_enable && (n_wake_counter >= n_wake_threshold)) begin
                n_irq_pending[0] = 1'b1;
            end
            if (w_check_dog && n_dog_enable) begin
                if (n_dog_counter >= n_bark_threshold) begin
                    n_irq_pending[1] = 1'b1;
                end
                if (n_dog_counter >= n_bite_threshold) begin
                    n_bitten = 1'b1;
                end
            end
        end

        w_result.read_data   = w_read_data;
        w_result.wakeup_irq  = n_irq_pending[0];
        w_result.bark_irq    = n_irq_pending[1];
        w_result.bite_reset  = n_bitten;
        w_result.fatal_alert = n_alert_latched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_wake_enable    <= 1'b0;
            r_wake_prescale  <= '0;
            r_prescale_phase <= '0;
            r_wake_threshold <= '0;
            r_wake_counter   <= '0;
            r_dog_write_open <= 1'b1;
            r_dog_enable     <= 1'b0;
            r_dog_pause_bit  <= 1'b0;
            r_bark_threshold <= '0;
            r_bite_threshold <= '0;
            r_dog_counter    <= '0;
            r_irq_pending    <= '0;
            r_bitten         <= 1'b0;
            r_alert_latched  <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_wake_enable    <= n_wake_enable;
            r_wake_prescale  <= n_wake_prescale;
            r_prescale_phase <= n_prescale_phase;
            r_wake_threshold <= n_wake_threshold;
            r_wake_counter   <= n_wake_counter;
            r_dog_write_open <= n_dog_write_open;
            r_dog_enable     <= n_dog_enable;
            r_dog_pause_bit  <= n_dog_pause_bit;
            r_bark_threshold <= n_bark_threshold;
            r_bite_threshold <= n_bite_threshold;
            r_dog_counter    <= n_dog_counter;
            r_irq_pending    <= n_irq_pending;
            r_bitten         <= n_bitten;
            r_alert_latched  <= n_alert_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    // The bite request and the fatal alert are only ever cleared by reset.
    `WTBW_ASSERT(a_bite_sticky, r_bitten |=> r_bitten, "Bite request was dropped.")
    `WTBW_ASSERT(a_alert_sticky, r_alert_latched |=> r_alert_latched, "Fatal alert was dropped.")
    // Once the watchdog write enable is cleared, it and the locked settings must not change.
    `WTBW_ASSERT(a_regwen_clear_only, !r_dog_write_open |=> !r_dog_write_open,
                 "Watchdog write enable was set again.")
    `WTBW_ASSERT(a_locked_dog_config, !r_dog_write_open |=> $stable(r_dog_enable)
                 && $stable(r_bark_threshold) && $stable(r_bite_threshold),
                 "Locked watchdog settings changed.")
    // A held result must never be overwritten while the output is stalled.
    `WTBW_ASSERT(a_no_overrun, r_out_valid && i_out_stall |-> !w_advance,
                 "Result register was overwritten while stalled.")

endmodule
